>>> hw/rtl/mvdt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvdt_pkg : shared types and constants
// Opcodes, controller states, command struct and sizing for the valve timer.
// ----------------------------------------------------------------------------
package mvdt_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int MASK_CHANNELS = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;

    localparam int TIMEOUT_W = 27;
    localparam int TIME_W    = 32;

    localparam logic [TIME_W-1:0]    MS_PER_MINUTE = 32'd60000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 27'd600000;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_TOGGLE    = 2'd1,
        OP_SCHEDULE  = 2'd2,
        OP_CLOSE_ALL = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/mvdt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvdt_ctrl : sequencing controller
// Captures an item, then commits it once the output register is free.
// ----------------------------------------------------------------------------
module mvdt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output mvdt_pkg::cmd_t     cmd
);

    mvdt_pkg::state_t state_reg;
    mvdt_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             can_commit;

    assign can_commit = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvdt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mvdt_pkg::ST_EXEC;
                end
            end
            mvdt_pkg::ST_EXEC:
            begin
                if (can_commit)
                begin
                    state_next = mvdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        in_stall    = 1'b1;
        case (state_reg)
            mvdt_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            mvdt_pkg::ST_EXEC:
            begin
                cmd.commit = can_commit;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign out_valid_next = cmd.commit || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvdt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mvdt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvdt_datapath : channel state, time counter and result register
// Holds per-channel open/deadline/manual state and applies one item per commit.
// ----------------------------------------------------------------------------
module mvdt_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mvdt_pkg::cmd_t                     cmd,
    input  wire logic                               cfg_we,
    input  wire logic [mvdt_pkg::TIMEOUT_W-1:0]     cfg_data,
    input  wire logic [1:0]                         opcode,
    input  wire logic [2:0]                         channel,
    input  wire logic [15:0]                        duration_minutes,
    output logic [7:0]                              open_mask,
    output logic                                    channel_open,
    output logic                                    timeout_flag,
    output logic [2:0]                              timeout_channel,
    output logic                                    any_open
);

    localparam int N  = mvdt_pkg::NUM_CHANNELS;
    localparam int TW = mvdt_pkg::TIME_W;

    logic [mvdt_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [TW-1:0]                  now_reg;
    logic [TW-1:0]                  now_next;
    logic [N-1:0]                   open_reg;
    logic [N-1:0]                   open_next;
    logic [N-1:0]                   manual_reg;
    logic [N-1:0]                   manual_next;
    logic [TW-1:0]                  deadline_reg [N];
    logic [TW-1:0]                  deadline_next [N];

    mvdt_pkg::op_t                  op_reg;
    logic [2:0]                     ch_reg;
    logic [TW-1:0]                  prod_reg;

    logic [7:0]                     mask_next;
    logic                           chopen_next;
    logic                           tflag_next;
    logic [2:0]                     tch_next;
    logic                           any_next;

    logic                           ch_valid;
    logic [N-1:0]                   sel;
    logic [TW-1:0]                  manual_dl;
    logic [TW-1:0]                  sched_dl;

    always_comb
    begin
        logic          done;
        logic [TW-1:0] diff;
        now_next    = now_reg;
        open_next   = open_reg;
        manual_next = manual_reg;
        tflag_next  = 1'b0;
        tch_next    = 3'd0;
        done        = 1'b0;
        diff        = '0;
        ch_valid    = int'(ch_reg) < N;
        manual_dl   = now_reg + {{(TW - mvdt_pkg::TIMEOUT_W){1'b0}}, timeout_reg};
        sched_dl    = now_reg + prod_reg;
        for (int i = 0; i < N; i++)
        begin
            deadline_next[i] = deadline_reg[i];
            sel[i]           = ch_valid && (int'(ch_reg) == i);
        end
        case (op_reg)
            mvdt_pkg::OP_TICK:
            begin
                now_next = now_reg + 1'b1;
                for (int i = 0; i < N; i++)
                begin
                    diff = now_next - deadline_reg[i];
                    if (!done && open_reg[i] && !diff[TW-1])
                    begin
                        open_next[i]     = 1'b0;
                        manual_next[i]   = 1'b0;
                        deadline_next[i] = '0;
                        if (manual_reg[i])
                        begin
                            done       = 1'b1;
                            tflag_next = 1'b1;
                            tch_next   = 3'(i);
                        end
                    end
                end
            end
            mvdt_pkg::OP_TOGGLE:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (sel[i])
                    begin
                        if (!open_reg[i])
                        begin
                            open_next[i]     = 1'b1;
                            manual_next[i]   = 1'b1;
                            deadline_next[i] = manual_dl;
                        end
                        else
                        begin
                            open_next[i]     = 1'b0;
                            manual_next[i]   = 1'b0;
                            deadline_next[i] = '0;
                        end
                    end
                end
            end
            mvdt_pkg::OP_SCHEDULE:
            begin
                for (int i = 0; i < N; i++)
                begin
                    diff = sched_dl - deadline_reg[i];
                    if (sel[i] && (prod_reg != '0)
                        && (!open_reg[i] || ((diff != '0) && !diff[TW-1])))
                    begin
                        open_next[i]     = 1'b1;
                        manual_next[i]   = 1'b0;
                        deadline_next[i] = sched_dl;
                    end
                end
            end
            mvdt_pkg::OP_CLOSE_ALL:
            begin
                open_next   = '0;
                manual_next = '0;
                for (int i = 0; i < N; i++)
                begin
                    deadline_next[i] = '0;
                end
            end
            default:
            begin
                now_next = now_reg;
            end
        endcase

        mask_next   = '0;
        chopen_next = 1'b0;
        for (int i = 0; i < mvdt_pkg::MASK_CHANNELS; i++)
        begin
            mask_next[i] = open_next[i];
        end
        for (int i = 0; i < N; i++)
        begin
            if (sel[i])
            begin
                chopen_next = open_next[i];
            end
        end
        any_next = |open_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= mvdt_pkg::TIMEOUT_RESET;
            now_reg     <= '0;
            open_reg    <= '0;
            manual_reg  <= '0;
            for (int i = 0; i < N; i++)
            begin
                deadline_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                now_reg    <= now_next;
                open_reg   <= open_next;
                manual_reg <= manual_next;
                for (int i = 0; i < N; i++)
                begin
                    deadline_reg[i] <= deadline_next[i];
                end
            end
        end
    end

    // item latch and result register: payload only
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= mvdt_pkg::op_t'(opcode);
            ch_reg   <= channel;
            prod_reg <= {16'd0, duration_minutes} * mvdt_pkg::MS_PER_MINUTE;
        end
        if (cmd.commit)
        begin
            open_mask       <= mask_next;
            channel_open    <= chopen_next;
            timeout_flag    <= tflag_next;
            timeout_channel <= tch_next;
            any_open        <= any_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/multi_channel_valve_deadline_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_valve_deadline_timer : eight-channel valve deadline timer
// Input channel (in_valid/in_stall) carries opcode, channel, duration_minutes:
// tick one millisecond, toggle, schedule or close all. Each transfer yields
// one result on the output channel (out_valid/out_stall): open mask, state of
// the addressed channel, manual timeout report and any-open flag.
// An item is captured in the idle state, where duration * 60000 is formed in
// the product register; the execute state then runs the deadline compares and
// priority scan and updates channel state, and in_stall holds off new items.
// The result stands in an output register; while the receiver stalls, the
// next item is still captured but its commit waits until the register frees.
// manual_timeout_ms is written through cfg_valid/cfg_ready/cfg_data, always
// ready; the user must write it only while the block is idle (not enforced).
// Reset: time counter zero, all channels closed, timeout 600000 ms, no
// result pending.
// ----------------------------------------------------------------------------
module multi_channel_valve_deadline_timer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [2:0]  channel,
    input  wire logic [15:0] duration_minutes,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       open_mask,
    output logic             channel_open,
    output logic             timeout_flag,
    output logic [2:0]       timeout_channel,
    output logic             any_open,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [26:0] cfg_data
);

    mvdt_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    mvdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mvdt_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .opcode           (opcode),
        .channel          (channel),
        .duration_minutes (duration_minutes),
        .open_mask        (open_mask),
        .channel_open     (channel_open),
        .timeout_flag     (timeout_flag),
        .timeout_channel  (timeout_channel),
        .any_open         (any_open)
    );

endmodule
`default_nettype wire
